// ===== rtl/mpd_pkg.sv =====
// Shared types and constants for the mouse packet decoder.
package mpd_pkg;

    // Field widths of one input byte and one movement event
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MOVE_X_W  = 9;
    localparam int unsigned MOVE_Y_W  = 10;
    localparam int unsigned WHEEL_W   = 5;
    localparam int unsigned BUTTONS_W = 3;
    localparam int unsigned EVENT_W   = MOVE_X_W + MOVE_Y_W + WHEEL_W + BUTTONS_W;
    localparam int unsigned OUT_TDATA_W = ((EVENT_W + 7) / 8) * 8;

    // Byte position within a packet
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // Bits of the first packet byte
    localparam int unsigned SYNC_BIT    = 3;
    localparam int unsigned X_SIGN_BIT  = 4;
    localparam int unsigned Y_SIGN_BIT  = 5;
    localparam int unsigned X_OVFL_BIT  = 6;
    localparam int unsigned Y_OVFL_BIT  = 7;

    // Wheel clamp limits
    localparam logic signed [BYTE_W-1:0] WHEEL_MAX = 8'sd8;
    localparam logic signed [BYTE_W-1:0] WHEEL_MIN = -8'sd8;

    // Completed packet handed from the assembler to the event formatter
    typedef struct packed {
        logic              done;
        logic              has_wheel;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
    } t_packet;

    // One movement event, last field in the low bits when flattened
    typedef struct packed {
        logic [BUTTONS_W-1:0]       buttons;
        logic signed [WHEEL_W-1:0]  move_wheel;
        logic signed [MOVE_Y_W-1:0] move_y;
        logic signed [MOVE_X_W-1:0] move_x;
    } t_event;

endpackage

// ===== rtl/mouse_packet_decoder_core.sv =====
// Top level of the mouse packet decoder: input register, assembler, formatter, result register.
//
// Usage: mouse bytes enter one per request on the slave stream (s_axis, 8-bit
// tdata). Each completed, non-overflowed packet leaves as one movement event
// on the master stream (m_axis, 32-bit tdata). Bytes that do not complete a
// packet, bytes dropped while hunting for sync and overflow packets give no
// output request.
// An event is formed from the byte in the input register that completes its
// packet and leaves through the result register. Throughput: one byte per
// cycle unless the receiver stalls; the assembler state update and the
// event formatting both fit in the single stage between the registers.
// Reset (synchronous, active low) empties both registers, returns the
// assembler to the first byte of a packet and clears wheel mode.
// When the receiver stalls, the result register holds its event and the
// input register keeps its byte; s_axis_tready drops only when both are full.
// The user writes wheel_mode through i_cfg_wr_en / i_cfg_wr_data only while idle; the block does not enforce it.
module mouse_packet_decoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mpd_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] data_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [8:0] move_x, [18:9] move_y, [23:19] move_wheel, [26:24] buttons, rest zero
    output logic [mpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import mpd_pkg::*;

    logic              r_wheel_mode;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_event            r_out_event;
    logic              advance;
    logic              ev_valid;
    t_packet           packet;
    t_event            ev;

    // Stage advances when the result register is free or being emptied
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_wheel_mode <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    mpd_assembler u_assembler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (r_in_valid && advance),
        .i_wheel_mode (r_wheel_mode),
        .i_byte       (r_in_byte),
        .o_packet     (packet)
    );

    mpd_event_fmt u_event_fmt (
        .i_packet (packet),
        .o_valid  (ev_valid),
        .o_event  (ev)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && ev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && ev_valid) begin
            r_out_event <= ev;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_event);

endmodule

// ===== rtl/mpd_assembler.sv =====
// Packet assembler: tracks byte position, stores the first bytes, flags a complete packet.
module mpd_assembler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic                      i_wheel_mode,
    input  logic [mpd_pkg::BYTE_W-1:0] i_byte,
    output mpd_pkg::t_packet          o_packet
);
    import mpd_pkg::*;

    logic [1:0]        r_pos;
    logic [1:0]        n_pos;
    logic [BYTE_W-1:0] r_bytes [3];
    logic              sync_miss;
    logic              last_byte;
    logic              store_en;

    // Decide whether this byte is dropped, stored or completes the packet
    always_comb begin
        sync_miss = (r_pos == POS_FIRST) && !i_byte[SYNC_BIT];
        if (i_wheel_mode) begin
            last_byte = (r_pos == POS_FOURTH);
        end else begin
            last_byte = (r_pos == POS_THIRD) || (r_pos == POS_FOURTH);
        end
        store_en = !sync_miss && !last_byte;
        n_pos    = r_pos;
        if (!sync_miss) begin
            n_pos = last_byte ? POS_FIRST : r_pos + 2'd1;
        end
    end

    // Advance the byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_FIRST;
        end else if (i_advance) begin
            r_pos <= n_pos;
        end
    end

    // Hold the leading packet bytes
    always_ff @(posedge i_clk) begin
        if (i_advance && store_en) begin
            r_bytes[r_pos] <= i_byte;
        end
    end

    // Present the completed packet
    always_comb begin
        o_packet.done      = !sync_miss && last_byte;
        o_packet.has_wheel = i_wheel_mode;
        o_packet.b0        = r_bytes[0];
        o_packet.b1        = r_bytes[1];
        o_packet.b2        = (r_pos == POS_THIRD) ? i_byte : r_bytes[2];
        o_packet.b3        = (r_pos == POS_FOURTH) ? i_byte : '0;
    end

endmodule

// ===== rtl/mpd_event_fmt.sv =====
// Event formatter: drops overflow packets and builds the movement event.
module mpd_event_fmt (
    input  mpd_pkg::t_packet i_packet,
    output logic             o_valid,
    output mpd_pkg::t_event  o_event
);
    import mpd_pkg::*;

    logic signed [MOVE_X_W-1:0] dy9;
    logic signed [BYTE_W-1:0]   wheel_raw;

    always_comb begin
        o_valid = i_packet.done && !i_packet.b0[X_OVFL_BIT] && !i_packet.b0[Y_OVFL_BIT];

        // Sign bits of the first byte extend the movement bytes to nine bits
        o_event.move_x = {i_packet.b0[X_SIGN_BIT], i_packet.b1};
        dy9            = {i_packet.b0[Y_SIGN_BIT], i_packet.b2};
        o_event.move_y = -MOVE_Y_W'(dy9);

        // Clamp the wheel count, zero without a wheel
        wheel_raw = i_packet.b3;
        if (!i_packet.has_wheel) begin
            o_event.move_wheel = '0;
        end else if (wheel_raw > WHEEL_MAX) begin
            o_event.move_wheel = WHEEL_MAX[WHEEL_W-1:0];
        end else if (wheel_raw < WHEEL_MIN) begin
            o_event.move_wheel = WHEEL_MIN[WHEEL_W-1:0];
        end else begin
            o_event.move_wheel = wheel_raw[WHEEL_W-1:0];
        end

        o_event.buttons = i_packet.b0[BUTTONS_W-1:0];
    end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the mouse packet decoder: directed and random byte streams against a predictor.
module tb;
    import mpd_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES   = 175;
    localparam int LIMIT_CYCLES  = 400000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic                   i_cfg_wr_data = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Bytes waiting to be sent, and events the decoder still owes us
    logic [BYTE_W-1:0] byte_queue[$];
    t_event            event_queue[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_bytes     = 1'b0;
    int errors         = 0;

    // Predictor state: wheel setting, packet position and stored bytes
    logic              wheel_cfg = 1'b0;
    logic [1:0]        asm_pos   = POS_FIRST;
    logic [BYTE_W-1:0] asm_bytes[3];

    mouse_packet_decoder_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Advance the packet assembler by one byte and queue the event it yields
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] b0, b1, b2, b3;
        int     want, dx, dy, neg_dy, dz;
        t_event ev;
        want = wheel_cfg ? 4 : 3;
        // Hunt for sync: drop bytes without the always-one bit
        if (asm_pos == POS_FIRST && !b[SYNC_BIT]) return;
        if (int'(asm_pos) + 1 < want) begin
            asm_bytes[asm_pos] = b;
            asm_pos = asm_pos + 2'd1;
            return;
        end
        b0 = asm_bytes[0];
        b1 = asm_bytes[1];
        if (asm_pos == POS_THIRD) begin
            b2 = b;
            b3 = '0;
        end else begin
            // Fourth byte; used as wheel data only if wheel mode is still on
            b2 = asm_bytes[2];
            b3 = b;
        end
        asm_pos = POS_FIRST;
        // Drop overflowed packets
        if (b0[X_OVFL_BIT] || b0[Y_OVFL_BIT]) return;
        dx = int'(b1) - (b0[X_SIGN_BIT] ? 256 : 0);
        dy = int'(b2) - (b0[Y_SIGN_BIT] ? 256 : 0);
        neg_dy = -dy;
        dz = 0;
        if (wheel_cfg) begin
            dz = int'($signed(b3));
            if (dz > int'(WHEEL_MAX)) dz = int'(WHEEL_MAX);
            if (dz < int'(WHEEL_MIN)) dz = int'(WHEEL_MIN);
        end
        ev.move_x     = dx[MOVE_X_W-1:0];
        ev.move_y     = neg_dy[MOVE_Y_W-1:0];
        ev.move_wheel = dz[WHEEL_W-1:0];
        ev.buttons    = b0[BUTTONS_W-1:0];
        event_queue.push_back(ev);
    endtask

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endfunction

    // Compare one output event with the oldest expectation
    task automatic check_event(input logic [OUT_TDATA_W-1:0] data);
        t_event got, want_ev;
        got = t_event'(data[EVENT_W-1:0]);
        if (event_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected event: expected none, got 0x%08h", $time, data);
        end else begin
            want_ev = event_queue.pop_front();
            check_field("move_x", int'(want_ev.move_x), int'(got.move_x));
            check_field("move_y", int'(want_ev.move_y), int'(got.move_y));
            check_field("move_wheel", int'(want_ev.move_wheel), int'(got.move_wheel));
            check_field("buttons", int'(want_ev.buttons), int'(got.buttons));
        end
    endtask

    // Driver: present the next byte once the current request is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (byte_queue.size() > 0 && !hold_bytes &&
                $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= byte_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random
    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on accepted bytes, check accepted events
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) check_event(m_axis_tdata);
        end
    end

    // Queue the first n bytes of a packet
    task automatic send_packet(input int n, input logic [BYTE_W-1:0] a, b, c, d);
        if (n > 0) byte_queue.push_back(a);
        if (n > 1) byte_queue.push_back(b);
        if (n > 2) byte_queue.push_back(c);
        if (n > 3) byte_queue.push_back(d);
    endtask

    // Wait until every byte is taken and every event has arrived, then let the pipe empty
    task automatic drain();
        do @(negedge i_clk);
        while (byte_queue.size() != 0 || s_axis_tvalid || event_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_wheel(input logic value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        wheel_cfg     = value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly well-formed packets, with lone noise bytes and truncated packets
    task automatic gen_traffic(input int n_bytes);
        int sent, r, want, cut;
        logic [BYTE_W-1:0] b0, b3;
        sent = 0;
        while (sent < n_bytes) begin
            want = wheel_cfg ? 4 : 3;
            r    = $urandom_range(99);
            b0   = 8'($urandom);
            b0[SYNC_BIT] = 1'b1;
            if ($urandom_range(9) != 0) begin
                b0[X_OVFL_BIT] = 1'b0;
                b0[Y_OVFL_BIT] = 1'b0;
            end
            // Wheel byte: half full range, half near the clamp limits
            b3 = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(20) - 10);
            if (r < 75) begin
                cut = want;
            end else if (r < 90) begin
                cut = 1;
                b0  = 8'($urandom);
            end else begin
                cut = $urandom_range(want - 1, 1);
            end
            send_packet(cut, b0, 8'($urandom), 8'($urandom), b3);
            sent += cut;
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit pause);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        gen_traffic(PHASE_BYTES);
        if (pause) begin
            // Hold the sender until every owed event has come out
            do @(negedge i_clk);
            while (byte_queue.size() > PHASE_BYTES / 2);
            hold_bytes = 1'b1;
            do @(negedge i_clk);
            while (s_axis_tvalid || event_queue.size() != 0);
            hold_bytes = 1'b0;
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Three-byte packets: resync, extremes, both overflow bits
        write_wheel(1'b0);
        send_packet(1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_packet(3, 8'h3F, 8'h00, 8'h00, 8'h00);
        send_packet(3, 8'h0F, 8'hFF, 8'hFF, 8'h00);
        send_packet(3, 8'h48, 8'h11, 8'h22, 8'h00);
        send_packet(3, 8'h88, 8'h33, 8'h44, 8'h00);
        drain();

        // Wheel packets at both clamps, then leave one at the fourth byte
        write_wheel(1'b1);
        send_packet(4, 8'h08, 8'h01, 8'h02, 8'h7F);
        send_packet(4, 8'h2C, 8'h03, 8'h04, 8'h80);
        send_packet(3, 8'h0D, 8'h10, 8'h20, 8'h00);
        drain();

        // Clear wheel mode mid-packet: next byte only completes the packet
        write_wheel(1'b0);
        send_packet(1, 8'hAA, 8'h00, 8'h00, 8'h00);
        send_packet(2, 8'h0A, 8'h05, 8'h00, 8'h00);
        drain();

        // Set wheel mode mid-packet: the packet now needs four bytes
        write_wheel(1'b1);
        send_packet(2, 8'h06, 8'hF8, 8'h00, 8'h00);
        drain();

        // Random traffic across idling and stalling patterns and both wheel settings
        write_wheel(1'b0);
        run_phase(0, 0, 1'b1);
        write_wheel(1'b1);
        run_phase(0, 0, 1'b0);
        write_wheel(1'b0);
        run_phase(47, 0, 1'b0);
        write_wheel(1'b1);
        run_phase(47, 0, 1'b0);
        write_wheel(1'b0);
        run_phase(0, 47, 1'b0);
        write_wheel(1'b1);
        run_phase(0, 47, 1'b0);
        write_wheel(1'b0);
        run_phase(11, 11, 1'b0);
        write_wheel(1'b1);
        run_phase(11, 11, 1'b0);

        if (errors == 0) begin
            $display("mouse_packet_decoder_core test passed");
        end else begin
            $display("mouse_packet_decoder_core test failed");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #(LIMIT_CYCLES * 4);
        $display("mouse_packet_decoder_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mpd_pkg.sv
rtl/mpd_assembler.sv
rtl/mpd_event_fmt.sv
rtl/mouse_packet_decoder_core.sv
sim/tb.sv
